// ===== design/csv_ftok_pkg.sv =====
// Shared types and constants for the CSV field tokenizer.
// Holds the result kinds, register indexes, flag and result bundle types.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package csv_ftok_pkg;

    // Fixed byte codes and register reset values.
    localparam logic [7:0] BYTE_LF         = 8'h0A;
    localparam logic [7:0] BYTE_CR         = 8'h0D;
    localparam logic [7:0] FIELD_SEP_RESET = 8'd44;
    localparam logic [7:0] TEXT_SEP_RESET  = 8'd34;

    // Configuration register indexes.
    localparam logic REG_FIELD_SEP = 1'b0;
    localparam logic REG_TEXT_SEP  = 1'b1;

    // Kind of one result word.
    typedef enum logic [2:0] {
        KIND_CONTENT      = 3'd0,
        KIND_FIELD_END    = 3'd1,
        KIND_RECORD_END   = 3'd2,
        KIND_EMPTY_RECORD = 3'd3,
        KIND_UNTERMINATED = 3'd4
    } kind_t;

    // One result word.
    typedef struct packed {
        logic [7:0] ch;
        kind_t      kind;
    } result_t;

    // All results caused by one input byte, slot 0 delivered first.
    typedef struct packed {
        result_t [2:0] res;
        logic [1:0]    count;
    } bundle_t;

    // Parser flag state.
    typedef struct packed {
        logic inside_quotes;
        logic field_is_quoted;
        logic quote_held;
        logic at_field_start;
        logic at_line_start;
        logic skip_next_lf;
    } flags_t;

    localparam flags_t FLAGS_RESET = '{
        inside_quotes:   1'b0,
        field_is_quoted: 1'b0,
        quote_held:      1'b0,
        at_field_start:  1'b1,
        at_line_start:   1'b1,
        skip_next_lf:    1'b0
    };

endpackage

// ===== design/csv_ftok_parse.sv =====
// Parser stage: flag registers and the per-byte decode into a result bundle.
// Depends on csv_ftok_pkg for the flag, result and bundle types.
`timescale 1ns / 1ps

module csv_ftok_parse (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [7:0]           in_char,
    input  logic                 end_of_input,
    input  logic [7:0]           field_sep,
    input  logic [7:0]           text_sep,
    output csv_ftok_pkg::bundle_t bundle
);

    csv_ftok_pkg::flags_t flags_reg;
    csv_ftok_pkg::flags_t flags_next;

    // Append one result to a bundle; a full bundle is left unchanged.
    function automatic csv_ftok_pkg::bundle_t push(
        csv_ftok_pkg::bundle_t b,
        csv_ftok_pkg::kind_t   kind,
        logic [7:0]            ch
    );
        csv_ftok_pkg::bundle_t r;
        r = b;
        if (b.count != 2'd3) begin
            r.res[b.count].kind = kind;
            r.res[b.count].ch   = (kind == csv_ftok_pkg::KIND_CONTENT) ? ch : 8'd0;
            r.count             = b.count + 2'd1;
        end
        return r;
    endfunction

    // Decode the held byte against the current flags.
    always_comb begin
        csv_ftok_pkg::flags_t  st;
        csv_ftok_pkg::bundle_t b;
        logic                  drop;
        st   = flags_reg;
        b    = '0;
        drop = 1'b0;

        if (in_char == text_sep) begin
            // Quote meaning wins over every other byte meaning.
            st.skip_next_lf = 1'b0;
            if (st.quote_held) begin
                b                = push(b, csv_ftok_pkg::KIND_CONTENT, in_char);
                st.quote_held    = 1'b0;
                st.inside_quotes = !st.inside_quotes;
            end else if (st.at_field_start && !st.inside_quotes) begin
                st.field_is_quoted = 1'b1;
                st.inside_quotes   = 1'b1;
                st.at_field_start  = 1'b0;
                st.at_line_start   = 1'b0;
            end else begin
                st.quote_held     = 1'b1;
                st.inside_quotes  = !st.inside_quotes;
                st.at_field_start = 1'b0;
                st.at_line_start  = 1'b0;
            end
        end else begin
            // A held quote not followed by a quote is resolved first.
            if (st.quote_held) begin
                st.quote_held = 1'b0;
                if (!st.field_is_quoted) begin
                    b = push(b, csv_ftok_pkg::KIND_CONTENT, text_sep);
                end
            end
            if (st.skip_next_lf) begin
                st.skip_next_lf = 1'b0;
                drop            = (in_char == csv_ftok_pkg::BYTE_LF);
            end
            if (!drop) begin
                if (st.inside_quotes) begin
                    if (in_char == csv_ftok_pkg::BYTE_CR) begin
                        b = push(b, csv_ftok_pkg::KIND_CONTENT, csv_ftok_pkg::BYTE_LF);
                        st.skip_next_lf = 1'b1;
                    end else begin
                        b = push(b, csv_ftok_pkg::KIND_CONTENT, in_char);
                    end
                    st.at_field_start = 1'b0;
                    st.at_line_start  = 1'b0;
                end else if (in_char == field_sep) begin
                    b = push(b, csv_ftok_pkg::KIND_FIELD_END, 8'd0);
                    st.at_field_start  = 1'b1;
                    st.at_line_start   = 1'b0;
                    st.field_is_quoted = 1'b0;
                end else if (in_char == csv_ftok_pkg::BYTE_LF ||
                             in_char == csv_ftok_pkg::BYTE_CR) begin
                    b = push(b, st.at_line_start ? csv_ftok_pkg::KIND_EMPTY_RECORD
                                                 : csv_ftok_pkg::KIND_RECORD_END, 8'd0);
                    st.at_field_start  = 1'b1;
                    st.at_line_start   = 1'b1;
                    st.field_is_quoted = 1'b0;
                    st.skip_next_lf    = (in_char == csv_ftok_pkg::BYTE_CR);
                end else begin
                    b = push(b, csv_ftok_pkg::KIND_CONTENT, in_char);
                    st.at_field_start = 1'b0;
                    st.at_line_start  = 1'b0;
                end
            end
        end

        // End of text: close out a held quote, then the open quote or record.
        if (end_of_input) begin
            if (st.quote_held) begin
                st.quote_held = 1'b0;
                if (!st.field_is_quoted) begin
                    b = push(b, csv_ftok_pkg::KIND_CONTENT, text_sep);
                end
            end
            if (st.inside_quotes) begin
                b = push(b, csv_ftok_pkg::KIND_UNTERMINATED, 8'd0);
            end else if (!st.at_line_start) begin
                b = push(b, csv_ftok_pkg::KIND_RECORD_END, 8'd0);
            end
            st = csv_ftok_pkg::FLAGS_RESET;
        end

        flags_next = st;
        bundle     = b;
    end

    // Flags move only when the held byte passes into the result buffer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= csv_ftok_pkg::FLAGS_RESET;
        end else if (advance) begin
            flags_reg <= flags_next;
        end
    end

endmodule

// ===== design/csv_ftok_outbuf.sv =====
// Result buffer: holds up to three result words of one byte, hands them out
// one per cycle while m_ready is high; needs csv_ftok_pkg result/bundle types.
`timescale 1ns / 1ps

module csv_ftok_outbuf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  csv_ftok_pkg::bundle_t bundle,
    output logic                  load_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_char,
    output logic [2:0]            m_out_kind,
    output logic                  m_last_of_run
);

    csv_ftok_pkg::result_t [2:0] slots_reg;
    csv_ftok_pkg::result_t [2:0] slots_next;
    logic [1:0]                  remain_reg;
    logic [1:0]                  remain_next;
    logic                        take;

    assign take       = m_valid && m_ready;
    assign load_ready = (remain_reg == 2'd0) || (remain_reg == 2'd1 && m_ready);

    assign m_valid       = (remain_reg != 2'd0);
    assign m_out_char    = slots_reg[0].ch;
    assign m_out_kind    = slots_reg[0].kind;
    assign m_last_of_run = (remain_reg == 2'd1);

    // Load a new bundle, or shift the next word to the front when one is taken.
    always_comb begin
        slots_next  = slots_reg;
        remain_next = remain_reg;
        if (load) begin
            slots_next  = bundle.res;
            remain_next = bundle.count;
        end else if (take) begin
            slots_next[0] = slots_reg[1];
            slots_next[1] = slots_reg[2];
            remain_next   = remain_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= 2'd0;
        end else begin
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        slots_reg <= slots_next;
    end

endmodule

// ===== design/csv_field_tokenizer.sv =====
// Top level of the CSV field tokenizer: input register, configuration
// registers, parser stage and result buffer, plus a few assertions.
// Depends on csv_ftok_pkg, csv_ftok_parse and csv_ftok_outbuf.
`timescale 1ns / 1ps

// Usage:
// The s_ channel takes one byte of CSV text per word, with s_end_of_input
// set on the last byte of a text. The m_ channel gives result words: content
// bytes, field end, field and record end, empty record and unterminated
// quote markers; m_last_of_run marks the final word caused by one byte.
// A byte may cause no word at all (a dropped quote or the LF of a CRLF).
// The cfg channel writes the field separator (index 0) and the quote byte
// (index 1); it is always ready and is meant to be written while idle.
// An accepted byte waits in the byte register, then loads into the result
// buffer. Throughput: one byte per cycle while each byte makes at most one
// word and m_ready is high; a byte with more words holds the buffer until
// its last is taken, as the m_ channel moves one word per cycle when ready.
// The byte register and the three-word result buffer decouple the sides, so
// a byte is taken while the previous results still wait. When the receiver
// stalls, the result buffer holds and then the byte register fills, and
// s_ready drops. Reset empties both stages, restores the separators to
// comma and double quote, and puts the parser at the start of a record.

module csv_field_tokenizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic [2:0] m_out_kind,
    output logic       m_last_of_run,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    logic                  in_valid_reg;
    logic [7:0]            in_char_reg;
    logic                  in_eoi_reg;
    logic [7:0]            field_sep_reg;
    logic [7:0]            text_sep_reg;
    logic                  advance;
    logic                  load_ready;
    csv_ftok_pkg::bundle_t bundle;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && load_ready;
    assign s_ready   = !in_valid_reg || advance;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_sep_reg <= csv_ftok_pkg::FIELD_SEP_RESET;
            text_sep_reg  <= csv_ftok_pkg::TEXT_SEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                csv_ftok_pkg::REG_FIELD_SEP: field_sep_reg <= cfg_data;
                csv_ftok_pkg::REG_TEXT_SEP:  text_sep_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input byte register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_in_char;
            in_eoi_reg  <= s_end_of_input;
        end
    end

    csv_ftok_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .in_char      (in_char_reg),
        .end_of_input (in_eoi_reg),
        .field_sep    (field_sep_reg),
        .text_sep     (text_sep_reg),
        .bundle       (bundle)
    );

    csv_ftok_outbuf u_outbuf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance),
        .bundle        (bundle),
        .load_ready    (load_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_out_kind    (m_out_kind),
        .m_last_of_run (m_last_of_run)
    );

    // A word that is not the last of its byte is always followed by another.
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid)
        else $error("result run ended without a last word");

    // Marker words carry a zero byte.
    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind != csv_ftok_pkg::KIND_CONTENT |-> m_out_char == 8'd0)
        else $error("marker word with nonzero byte");

    // The unterminated quote flag always closes its run.
    a_unterm_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind == csv_ftok_pkg::KIND_UNTERMINATED |-> m_last_of_run)
        else $error("unterminated quote flag not last of run");

    // Input back-pressure only arises with a byte waiting in the register.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && !load_ready)
        else $error("s_ready low without a stalled byte");

endmodule
